[sv/equirectangular_distance_macros.svh]
// Assertion macros used by the checker of the distance unit.
`ifndef EQUIRECTANGULAR_DISTANCE_MACROS_SVH
`define EQUIRECTANGULAR_DISTANCE_MACROS_SVH

// The consequent must hold in the clock after the antecedent.
`define ED_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

// The consequent must hold in the same clock as the antecedent.
`define ED_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

`endif

[sv/ed_pkg.sv]
package ed_pkg;

    localparam int COORD_W  = 32;
    localparam int DIST_W   = 35;
    localparam int RADIUS_W = 24;

    // pi/180 in Q32.
    localparam int RAD_K_W = 27;
    localparam logic [RAD_K_W-1:0] DEG_TO_RAD_Q32 = 27'd74961321;

    localparam int Q30 = 30;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    // Exact floor division by 45 through a reciprocal, valid below 2^22.
    localparam int W45_W = 22;
    localparam int Q45_W = 17;
    localparam int R45_W = 25;
    localparam logic [R45_W-1:0] RECIP_45 = 25'(((64'd1 << 30) + 64'd44) / 64'd45);

    // Horner steps of the cosine series with their reciprocals.
    localparam int COS_STEPS = 5;
    localparam logic [6:0] COS_DIV [COS_STEPS] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
    localparam int COS_SHIFT [COS_STEPS] = '{38, 37, 36, 35, 32};
    localparam logic [31:0] COS_RECIP [COS_STEPS] = '{
        32'((64'd1 << 38) / 64'd90),
        32'((64'd1 << 37) / 64'd56),
        32'((64'd1 << 36) / 64'd30),
        32'((64'd1 << 35) / 64'd12),
        32'((64'd1 << 32) / 64'd2)
    };

    localparam int SUM_W  = 65;
    localparam int S_W    = 81;
    localparam int ROOT_W = 41;
    localparam int RK_W   = 51;
    localparam int PROD_W = 92;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic [0:0] {
        CFG_COORD_MODE   = 1'b0,
        CFG_EARTH_RADIUS = 1'b1
    } cfg_reg_t;

    // Data that travels beside the cosine evaluation.
    typedef struct packed {
        logic [31:0] dx;
        logic [31:0] dy;
        logic [31:0] d;
    } side_t;

    // Pipeline advance and the valid bit of the word entering a section.
    typedef struct packed {
        logic en;
        logic vld;
    } pipe_t;

endpackage

[sv/ed_point_if.sv]
interface ed_point_if import ed_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] lat_a;
    logic signed [COORD_W-1:0] lon_a;
    logic signed [COORD_W-1:0] lat_b;
    logic signed [COORD_W-1:0] lon_b;

    modport source (output valid, output lat_a, output lon_a, output lat_b, output lon_b,
                    input ready);
    modport sink (input valid, input lat_a, input lon_a, input lat_b, input lon_b,
                  output ready);
endinterface

[sv/ed_dist_if.sv]
interface ed_dist_if import ed_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;

    modport source (output valid, output distance, input ready);
    modport sink (input valid, input distance, output ready);
endinterface

[sv/ed_cfg_if.sv]
interface ed_cfg_if import ed_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [0:0]          index;
    logic [RADIUS_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[sv/equirectangular_distance.sv]
// Distance between two points given as latitude/y and longitude/x in units of
// 2^-COORD_FRAC_BITS, returned in units of 2^-8 metre (geodetic mode) or 2^-8 unit
// (Cartesian mode), saturated at the top of the 35-bit range. The unit takes one
// pair of points every clock cycle unless the result side stalls, and each word
// passes in order through differencing and angle folding, the five steps of the
// cosine series, the squares, the square root at one result bit per stage, and
// the radius scaling and saturation. A stall on the result side holds the whole
// pipeline, and words are never dropped.
// Configuration writes are always taken at once and must only be made while no
// word is in flight.
module equirectangular_distance import ed_pkg::*; #(
    parameter int COORD_FRAC_BITS = 16
) (
    input logic          clk,
    input logic          rst_n,
    ed_point_if.sink     points,
    ed_dist_if.source    result,
    ed_cfg_if.sink       cfg
);

    logic coord_mode_reg;
    logic [RADIUS_W-1:0] earth_radius_reg;
    logic en;
    pipe_t pin_front, pin_mid, pin_root, pin_scale;
    logic [31:0] u;
    side_t side_front, side_cos;
    logic [30:0] h;
    logic [ROOT_W-1:0] root;
    logic vld_front, vld_cos, vld_root, vld_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_mode_reg   <= 1'b1;
            earth_radius_reg <= 24'd6371000;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                CFG_COORD_MODE:   coord_mode_reg <= cfg.data[0];
                CFG_EARTH_RADIUS: earth_radius_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    // The whole pipeline advances unless the output word is waiting.
    assign en           = !vld_out || result.ready;
    assign points.ready = en;
    assign pin_front    = '{en: en, vld: points.valid};

    ed_front #(.FRAC_BITS(COORD_FRAC_BITS)) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .pin   (pin_front),
        .lat_a (points.lat_a),
        .lon_a (points.lon_a),
        .lat_b (points.lat_b),
        .lon_b (points.lon_b),
        .u     (u),
        .side  (side_front),
        .vld   (vld_front)
    );

    assign pin_mid = '{en: en, vld: vld_front};

    ed_cos u_cos (
        .clk      (clk),
        .rst_n    (rst_n),
        .pin      (pin_mid),
        .u        (u),
        .side     (side_front),
        .h        (h),
        .side_out (side_cos),
        .vld      (vld_cos)
    );

    assign pin_root = '{en: en, vld: vld_cos};

    ed_root #(.FRAC_BITS(COORD_FRAC_BITS)) u_root (
        .clk        (clk),
        .rst_n      (rst_n),
        .pin        (pin_root),
        .coord_mode (coord_mode_reg),
        .h          (h),
        .side       (side_cos),
        .root       (root),
        .vld        (vld_root)
    );

    assign pin_scale = '{en: en, vld: vld_root};

    ed_scale #(.FRAC_BITS(COORD_FRAC_BITS)) u_scale (
        .clk            (clk),
        .rst_n          (rst_n),
        .pin            (pin_scale),
        .coord_mode     (coord_mode_reg),
        .earth_radius_m (earth_radius_reg),
        .root           (root),
        .distance       (result.distance),
        .vld            (vld_out)
    );

    assign result.valid = vld_out;

endmodule

[sv/ed_front.sv]
module ed_front import ed_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pipe_t                     pin,
    input  logic signed [COORD_W-1:0] lat_a,
    input  logic signed [COORD_W-1:0] lon_a,
    input  logic signed [COORD_W-1:0] lat_b,
    input  logic signed [COORD_W-1:0] lon_b,
    output logic [31:0]               u,
    output side_t                     side,
    output logic                      vld
);

    localparam int STAGES = 5;
    localparam logic [33:0] FULL    = 34'(360) << FRAC_BITS;
    localparam logic [32:0] HALF    = 33'(180) << FRAC_BITS;
    localparam logic [32:0] QUARTER = 33'(90) << FRAC_BITS;

    logic [STAGES-1:0] vld_reg;

    logic signed [COORD_W:0] dlat, dlon, ext_a, ext_b;
    logic [31:0] dx_next, dy_next, mag_a, mag_b, m_next;
    logic [31:0] dx1_reg, dy1_reg, m1_reg;

    logic [W45_W-1:0] wd, wm;
    logic [Q45_W-1:0] qd_next, qm_next;
    logic [Q45_W-1:0] qd2_reg, qm2_reg;
    logic [31:0] dx2_reg, dy2_reg, m2_reg;

    logic [31:0] d_mod, d_next, m_mod, mf_next;
    logic [31:0] dx3_reg, dy3_reg, d3_reg, mf3_reg;

    logic [30:0] t_next;
    logic [30:0] t4_reg;
    side_t side4_reg;

    logic [31:0] u_next;
    logic [31:0] u5_reg;
    side_t side5_reg;

    // Differences and the larger latitude magnitude.
    always_comb
    begin
        dlat    = COORD_W'(0) + (33'(lat_a) - 33'(lat_b));
        dlon    = 33'(lon_a) - 33'(lon_b);
        ext_a   = 33'(lat_a);
        ext_b   = 33'(lat_b);
        dy_next = dlat[COORD_W] ? 32'(-dlat) : 32'(dlat);
        dx_next = dlon[COORD_W] ? 32'(-dlon) : 32'(dlon);
        mag_a   = ext_a[COORD_W] ? 32'(-ext_a) : 32'(ext_a);
        mag_b   = ext_b[COORD_W] ? 32'(-ext_b) : 32'(ext_b);
        m_next  = (mag_b > mag_a) ? mag_b : mag_a;
    end

    // Quotients by a full turn and by half a turn.
    always_comb
    begin
        wd      = W45_W'(dx1_reg >> (FRAC_BITS + 3));
        wm      = W45_W'(m1_reg >> (FRAC_BITS + 2));
        qd_next = Q45_W'((47'(wd) * 47'(RECIP_45)) >> 30);
        qm_next = Q45_W'((47'(wm) * 47'(RECIP_45)) >> 30);
    end

    // Remainders, then the folds.
    always_comb
    begin
        d_mod   = 32'(52'(dx2_reg) - 52'(qd2_reg) * 52'(FULL));
        d_next  = (33'(d_mod) > HALF) ? 32'(FULL - 34'(d_mod)) : d_mod;
        m_mod   = 32'(52'(m2_reg) - 52'(qm2_reg) * 52'(HALF));
        mf_next = (33'(m_mod) > QUARTER) ? 32'(HALF - 33'(m_mod)) : m_mod;
    end

    assign t_next = 31'((58'(mf3_reg) * 58'(DEG_TO_RAD_Q32)) >> (FRAC_BITS + 2));
    assign u_next = 32'((62'(t4_reg) * 62'(t4_reg)) >> Q30);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (pin.en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], pin.vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (pin.en)
        begin
            dx1_reg   <= dx_next;
            dy1_reg   <= dy_next;
            m1_reg    <= m_next;
            qd2_reg   <= qd_next;
            qm2_reg   <= qm_next;
            dx2_reg   <= dx1_reg;
            dy2_reg   <= dy1_reg;
            m2_reg    <= m1_reg;
            dx3_reg   <= dx2_reg;
            dy3_reg   <= dy2_reg;
            d3_reg    <= d_next;
            mf3_reg   <= mf_next;
            t4_reg    <= t_next;
            side4_reg <= '{dx: dx3_reg, dy: dy3_reg, d: d3_reg};
            u5_reg    <= u_next;
            side5_reg <= side4_reg;
        end
    end

    assign u    = u5_reg;
    assign side = side5_reg;
    assign vld  = vld_reg[STAGES-1];

endmodule

[sv/ed_cos.sv]
module ed_cos import ed_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  pipe_t       pin,
    input  logic [31:0] u,
    input  side_t       side,
    output logic [30:0] h,
    output side_t       side_out,
    output logic        vld
);

    localparam int STAGES = 3 * COS_STEPS;

    logic [STAGES-1:0] vld_reg;
    logic [30:0] h_in [COS_STEPS+1];
    logic [31:0] u_in [COS_STEPS+1];
    side_t       s_in [COS_STEPS+1];

    assign h_in[0] = Q30_ONE;
    assign u_in[0] = u;
    assign s_in[0] = side;

    // Each Horner step: product, reciprocal product, then correction and subtract.
    for (genvar i = 0; i < COS_STEPS; i++)
    begin : g_step
        logic [31:0] pm_a_reg, u_a_reg, pm_b_reg, q0_b_reg, u_b_reg, u_c_reg;
        logic [30:0] h_c_reg;
        side_t side_a_reg, side_b_reg, side_c_reg;
        logic [31:0] pm_next, q0_next, rem_b, q_b;
        logic [30:0] h_next;

        always_comb
        begin
            pm_next = 32'((62'(u_in[i]) * 62'(h_in[i])) >> Q30);
            q0_next = 32'((64'(pm_a_reg) * 64'(COS_RECIP[i])) >> COS_SHIFT[i]);
            rem_b   = pm_b_reg - 32'(39'(q0_b_reg) * 39'(COS_DIV[i]));
            q_b     = (rem_b >= 32'(COS_DIV[i])) ? 32'(q0_b_reg + 32'd1) : q0_b_reg;
            h_next  = (q_b >= 32'(Q30_ONE)) ? '0 : 31'(32'(Q30_ONE) - q_b);
        end

        always_ff @(posedge clk)
        begin
            if (pin.en)
            begin
                pm_a_reg   <= pm_next;
                u_a_reg    <= u_in[i];
                side_a_reg <= s_in[i];
                q0_b_reg   <= q0_next;
                pm_b_reg   <= pm_a_reg;
                u_b_reg    <= u_a_reg;
                side_b_reg <= side_a_reg;
                h_c_reg    <= h_next;
                u_c_reg    <= u_b_reg;
                side_c_reg <= side_b_reg;
            end
        end

        assign h_in[i+1] = h_c_reg;
        assign u_in[i+1] = u_c_reg;
        assign s_in[i+1] = side_c_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (pin.en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], pin.vld};
        end
    end

    assign h        = h_in[COS_STEPS];
    assign side_out = s_in[COS_STEPS];
    assign vld      = vld_reg[STAGES-1];

endmodule

[sv/ed_root.sv]
module ed_root import ed_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pipe_t             pin,
    input  logic              coord_mode,
    input  logic [30:0]       h,
    input  side_t             side,
    output logic [ROOT_W-1:0] root,
    output logic              vld
);

    localparam int STAGES = 3 + ROOT_W;

    logic [STAGES-1:0] vld_reg;
    logic [31:0] x_next, a_next;
    logic [31:0] a_reg, dy_reg;
    logic [63:0] sqa_reg, sqb_reg;
    logic [SUM_W-1:0] sum;
    logic [S_W-1:0] s_next, s_reg;

    logic [S_W-1:0]    rem_in  [ROOT_W+1];
    logic [ROOT_W-1:0] root_in [ROOT_W+1];

    always_comb
    begin
        x_next = 32'((63'(h) * 63'(side.d)) >> Q30);
        a_next = coord_mode ? x_next : side.dx;
        sum    = SUM_W'(sqa_reg) + SUM_W'(sqb_reg);
        s_next = coord_mode ? (S_W'(sum) << 16) : S_W'(sum >> (2 * FRAC_BITS - 16));
    end

    always_ff @(posedge clk)
    begin
        if (pin.en)
        begin
            a_reg   <= a_next;
            dy_reg  <= side.dy;
            sqa_reg <= 64'(a_reg) * 64'(a_reg);
            sqb_reg <= 64'(dy_reg) * 64'(dy_reg);
            s_reg   <= s_next;
        end
    end

    assign rem_in[0]  = s_reg;
    assign root_in[0] = '0;

    // One result bit per stage, most significant first, on a running remainder.
    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_bit
        localparam int B = ROOT_W - 1 - j;
        logic [S_W:0] trial;
        logic take;
        logic [S_W-1:0] rem_next, rem_reg;
        logic [ROOT_W-1:0] root_next, root_reg;

        always_comb
        begin
            trial     = ((S_W+1)'(root_in[j]) << (B + 1)) + ((S_W+1)'(1) << (2 * B));
            take      = ((S_W+1)'(rem_in[j]) >= trial);
            rem_next  = take ? S_W'((S_W+1)'(rem_in[j]) - trial) : rem_in[j];
            root_next = take ? (root_in[j] | (ROOT_W'(1) << B)) : root_in[j];
        end

        always_ff @(posedge clk)
        begin
            if (pin.en)
            begin
                rem_reg  <= rem_next;
                root_reg <= root_next;
            end
        end

        assign rem_in[j+1]  = rem_reg;
        assign root_in[j+1] = root_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (pin.en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], pin.vld};
        end
    end

    assign root = root_in[ROOT_W];
    assign vld  = vld_reg[STAGES-1];

endmodule

[sv/ed_scale.sv]
module ed_scale import ed_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pipe_t               pin,
    input  logic                coord_mode,
    input  logic [RADIUS_W-1:0] earth_radius_m,
    input  logic [ROOT_W-1:0]   root,
    output logic [DIST_W-1:0]   distance,
    output logic                vld
);

    localparam int STAGES = 3;

    logic [STAGES-1:0] vld_reg;
    logic [RK_W-1:0] rk_reg;
    logic [63:0] p00_reg;
    logic [50:0] p01_reg;
    logic [40:0] p10_reg;
    logic [27:0] p11_reg;
    logic [ROOT_W-1:0] root_p_reg, root_q_reg;
    logic [PROD_W-1:0] prod_next, prod_reg, shifted;
    logic [DIST_W-1:0] geo, cart, dist_next, dist_reg;

    // The user must change the radius only while idle (the block does not enforce it); rk_reg tracks it.
    always_ff @(posedge clk)
    begin
        rk_reg <= RK_W'(earth_radius_m) * RK_W'(DEG_TO_RAD_Q32);
    end

    always_comb
    begin
        prod_next = PROD_W'(p00_reg) + (PROD_W'(p01_reg) << 32) + (PROD_W'(p10_reg) << 32)
                  + (PROD_W'(p11_reg) << 64);
        shifted   = prod_reg >> (32 + FRAC_BITS);
        geo       = (shifted > PROD_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(shifted);
        cart      = (root_q_reg > ROOT_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(root_q_reg);
        dist_next = coord_mode ? geo : cart;
    end

    always_ff @(posedge clk)
    begin
        if (pin.en)
        begin
            p00_reg    <= 64'(root[31:0]) * 64'(rk_reg[31:0]);
            p01_reg    <= 51'(root[31:0]) * 51'(rk_reg[50:32]);
            p10_reg    <= 41'(root[40:32]) * 41'(rk_reg[31:0]);
            p11_reg    <= 28'(root[40:32]) * 28'(rk_reg[50:32]);
            root_p_reg <= root;
            prod_reg   <= prod_next;
            root_q_reg <= root_p_reg;
            dist_reg   <= dist_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (pin.en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], pin.vld};
        end
    end

    assign distance = dist_reg;
    assign vld      = vld_reg[STAGES-1];

endmodule

[sv/ed_checker.sv]
`include "equirectangular_distance_macros.svh"

module ed_checker import ed_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [DIST_W-1:0] distance,
    input logic              cfg_valid,
    input logic              cfg_ready
);

    // A waiting result word keeps its value until it is taken.
    `ED_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(distance), "result word changed while stalled")

    // Input is refused only while a finished word is held at the output.
    `ED_ASSERT_NOW(a_in_ready, clk, rst_n, in_valid || !in_valid, in_ready == (!out_valid || out_ready), "input ready does not follow the output stall")

    // Configuration writes are never held off.
    `ED_ASSERT_NOW(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready, "configuration write was stalled")

endmodule

bind equirectangular_distance ed_checker u_ed_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (points.valid),
    .in_ready  (points.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .distance  (result.distance),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready)
);
